>>> design/mlqd_pkg.sv
package mlqd_pkg;

    localparam int LEVELS_DEF      = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int PID_W  = 16;
    localparam int PRIO_W = 2;
    localparam int CODE_W = 2;
    localparam int LVL_W  = 2;

    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        RES_ENQUEUED   = 2'd0,
        RES_DROPPED    = 2'd1,
        RES_DISPATCHED = 2'd2,
        RES_EMPTY      = 2'd3
    } mlqd_code_t;

    typedef struct packed {
        mlqd_code_t       code;
        logic [LVL_W-1:0] level;
        logic             served;
    } mlqd_result_t;

endpackage

>>> design/multilevel_queue_slot_dispatcher.sv
// multilevel queue slot dispatcher
// input stream (s_axis): one transfer per request. s_axis_tuser carries the
// operation (enqueue or dispatch), s_axis_tdata the process id and its level.
// output stream (m_axis): exactly one transfer per request, in request order.
// m_axis_tuser carries the result code, m_axis_tdata the served id and level.
// the level select, pointer update and process-id store read (one synchronous read
// port) share the transfer cycle; the result is then registered in the pending
// register and moves on to the output register when that has room.
// a new request is taken only once the previous one has left the pending register.
// stall: a held output keeps its result; one more request is still taken and
// parked, after which s_axis_tready stays low until the output moves.
// reset: all level queues empty, every slot budget at its round start value;
// the block is ready in the first cycle after reset release, no clearing pass.
module multilevel_queue_slot_dispatcher #(
    parameter int LEVELS      = mlqd_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // process_id, priority_req, zero pad
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // dispatched_id, dispatched_level, zero pad
    output logic [1:0]  m_axis_tuser   // result_code
);
    import mlqd_pkg::*;

    localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

    logic              accept;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_addr;
    logic [PID_W-1:0]  mem_wdata;
    logic [PID_W-1:0]  mem_rdata;
    mlqd_result_t      result;
    logic [PID_W-1:0]  out_id;
    logic [LVL_W-1:0]  out_level;

    assign accept = s_axis_tvalid && s_axis_tready;

    mlqd_sched #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_sched (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (s_axis_tuser),
        .process_id   (s_axis_tdata[15:0]),
        .priority_req (s_axis_tdata[17:16]),
        .mem_wr_en    (mem_wr_en),
        .mem_rd_en    (mem_rd_en),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .result       (result)
    );

    mlqd_store #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mlqd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .result_in (result),
        .rd_data   (mem_rdata),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_code  (m_axis_tuser),
        .out_id    (out_id),
        .out_level (out_level)
    );

    assign m_axis_tdata = {6'b0, out_level, out_id};

endmodule

>>> design/mlqd_store.sv
module mlqd_store #(
    parameter int LEVELS      = mlqd_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlqd_pkg::QUEUE_DEPTH_DEF,
    localparam int ENTRIES    = LEVELS * QUEUE_DEPTH,
    localparam int AW         = $clog2(ENTRIES)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [AW-1:0]              addr,
    input  logic [mlqd_pkg::PID_W-1:0] wdata,
    output logic [mlqd_pkg::PID_W-1:0] rdata
);
    import mlqd_pkg::*;

    logic [PID_W-1:0] mem [ENTRIES];
    logic [PID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/mlqd_sched.sv
module mlqd_sched #(
    parameter int LEVELS      = mlqd_pkg::LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlqd_pkg::QUEUE_DEPTH_DEF,
    localparam int AW         = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        op,
    input  logic [mlqd_pkg::PID_W-1:0]  process_id,
    input  logic [mlqd_pkg::PRIO_W-1:0] priority_req,
    output logic                        mem_wr_en,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_addr,
    output logic [mlqd_pkg::PID_W-1:0]  mem_wdata,
    output mlqd_pkg::mlqd_result_t      result
);
    import mlqd_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = $clog2(LEVELS + 1);

    logic [PW-1:0] head_reg   [LEVELS];
    logic [PW-1:0] head_next  [LEVELS];
    logic [PW-1:0] tail_reg   [LEVELS];
    logic [PW-1:0] tail_next  [LEVELS];
    logic [CW-1:0] count_reg  [LEVELS];
    logic [CW-1:0] count_next [LEVELS];
    logic [BW-1:0] budget_reg [LEVELS];
    logic [BW-1:0] budget_next[LEVELS];
    logic [BW-1:0] budget_base[LEVELS];

    logic [LEVELS-1:0] qual;
    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] left;
    logic [LW-1:0]     sel_qual;
    logic [LW-1:0]     sel_any;
    logic [LW-1:0]     sel;
    logic              hit_qual;
    logic              hit_any;
    logic [LW-1:0]     enq_lv;
    logic              prio_ok;
    logic              enq_ok;

    function automatic logic [BW-1:0] budget_init(input int lv);
        return BW'(LEVELS - lv);
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign enq_lv  = LW'(priority_req);
    assign prio_ok = int'(priority_req) < LEVELS;
    assign enq_ok  = prio_ok && (count_reg[enq_lv] != CW'(QUEUE_DEPTH));

    // level select: lowest nonempty level with budget left wins, else lowest nonempty level
    always_comb
    begin
        sel_qual = '0;
        sel_any  = '0;
        for (int lv = LEVELS - 1; lv >= 0; lv--)
        begin
            nonempty[lv] = count_reg[lv] != '0;
            qual[lv]     = nonempty[lv] && (budget_reg[lv] != '0);
            if (qual[lv])
            begin
                sel_qual = LW'(lv);
            end
            if (nonempty[lv])
            begin
                sel_any = LW'(lv);
            end
        end
        hit_qual = |qual;
        hit_any  = |nonempty;
        sel      = hit_qual ? sel_qual : sel_any;
    end

    always_comb
    begin
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            head_next[lv]   = head_reg[lv];
            tail_next[lv]   = tail_reg[lv];
            count_next[lv]  = count_reg[lv];
            budget_base[lv] = hit_qual ? budget_reg[lv] : budget_init(lv);
            budget_next[lv] = budget_reg[lv];
            left[lv]        = 1'b0;
        end
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_addr      = '0;
        mem_wdata     = process_id;
        result.code   = RES_DROPPED;
        result.level  = '0;
        result.served = 1'b0;

        if (op == OP_ENQUEUE)
        begin
            mem_addr = AW'(enq_lv) * AW'(QUEUE_DEPTH) + AW'(tail_reg[enq_lv]);
            if (enq_ok)
            begin
                mem_wr_en          = accept;
                tail_next[enq_lv]  = ptr_inc(tail_reg[enq_lv]);
                count_next[enq_lv] = count_reg[enq_lv] + CW'(1);
                result.code        = RES_ENQUEUED;
            end
        end
        else
        begin
            mem_addr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(head_reg[sel]);
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                budget_next[lv] = budget_base[lv];
            end
            if (hit_any)
            begin
                mem_rd_en        = accept;
                head_next[sel]   = ptr_inc(head_reg[sel]);
                count_next[sel]  = count_reg[sel] - CW'(1);
                budget_next[sel] = budget_base[sel] - BW'(1);
                result.code      = RES_DISPATCHED;
                result.level     = LVL_W'(sel);
                result.served    = 1'b1;
            end
            else
            begin
                result.code = RES_EMPTY;
            end
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                left[lv] = budget_next[lv] != '0;
            end
            // round over, start the next one
            if (!(|left))
            begin
                for (int lv = 0; lv < LEVELS; lv++)
                begin
                    budget_next[lv] = budget_init(lv);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                head_reg[lv]   <= '0;
                tail_reg[lv]   <= '0;
                count_reg[lv]  <= '0;
                budget_reg[lv] <= budget_init(lv);
            end
        end
        else if (accept)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            budget_reg <= budget_next;
        end
    end

    logic [LEVELS-1:0] budget_live;
    logic [LEVELS-1:0] count_ok;

    always_comb
    begin
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            budget_live[lv] = budget_reg[lv] != '0;
            count_ok[lv]    = count_reg[lv] <= CW'(QUEUE_DEPTH);
        end
    end

    a_budget_never_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        |budget_live)
        else $error("all slot budgets zero between items");

    a_mem_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("store written and read for one item");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        &count_ok)
        else $error("level occupancy above queue depth");

    a_dispatch_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mem_rd_en) |=> (head_reg[$past(sel)] != $past(head_reg[sel])))
        else $error("dispatch left head pointer in place");

endmodule

>>> design/mlqd_out.sv
module mlqd_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  mlqd_pkg::mlqd_result_t        result_in,
    input  logic [mlqd_pkg::PID_W-1:0]    rd_data,
    input  logic                          out_ready,
    output logic                          in_ready,
    output logic                          out_valid,
    output logic [mlqd_pkg::CODE_W-1:0]   out_code,
    output logic [mlqd_pkg::PID_W-1:0]    out_id,
    output logic [mlqd_pkg::LVL_W-1:0]    out_level
);
    import mlqd_pkg::*;

    logic         pend_valid_reg;
    logic         pend_valid_next;
    mlqd_result_t pend_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic [PID_W-1:0]  out_id_reg;
    logic [LVL_W-1:0]  out_level_reg;
    logic         move;

    // pending item holds its result beside the registered store read until the output has room
    assign move     = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_valid_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= result_in;
        end
        if (move)
        begin
            out_code_reg  <= pend_reg.code;
            out_level_reg <= pend_reg.level;
            out_id_reg    <= pend_reg.served ? rd_data : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_id    = out_id_reg;
    assign out_level = out_level_reg;

endmodule
